@@ design/rte_pkg.sv @@
// ----------------------------------------------------------------------------
// rte_pkg: shared types for the route table
// Transfer payloads, the stored route word, comparator results and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package rte_pkg;

	localparam int SLOT_W = 4;

	typedef enum logic [1:0] {
		ACT_FIND   = 2'd0,
		ACT_UPSERT = 2'd1,
		ACT_EXPIRE = 2'd2,
		ACT_REMOVE = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		act_t              action;
		logic [15:0]       dest_addr;
		logic [15:0]       hop_addr;
		logic [15:0]       route_cost;
		logic [31:0]       time_now;
		logic [31:0]       life_span;
		logic [SLOT_W-1:0] slot_sel;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot_out;
		logic [15:0]       hop_out;
		logic [15:0]       cost_out;
		logic [31:0]       expiry_out;
	} rsp_t;

	typedef struct packed {
		logic [15:0] dest;
		logic [15:0] hop;
		logic [15:0] cost;
		logic [31:0] expiry;
	} entry_t;

	typedef struct packed {
		logic dest_eq;
		logic hop_eq;
		logic cost_lt;
		logic due;
		logic older;
	} cmp_t;

endpackage

@@ design/route_table_with_expiry.sv @@
// ----------------------------------------------------------------------------
// route_table_with_expiry: route table with time-to-live expiry
// Find, upsert, expire sweep and remove over a table of ROUTES routes.
// ----------------------------------------------------------------------------
// One request is handled at a time. Find, upsert and expire walk the whole
// table one entry per cycle through the single read port of the route memory:
// ST_SCAN reads every entry, ST_FLUSH retires the last read, and ST_DECIDE
// decides, where an upsert writes back; remove goes straight to ST_DECIDE.
// The decision holds while an earlier result is still stalled. The next
// request is taken in the cycle after the decision, even while that result
// is still waiting. Valid flags are cleared by reset directly, so the table
// is usable straight away. Entries that are not valid read as all zero.
module route_table_with_expiry #(
	parameter int ROUTES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rte_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rte_pkg::rsp_t rsp
);
	import rte_pkg::*;

	localparam int IW = $clog2(ROUTES);
	localparam logic [IW-1:0] LAST_IDX = IW'(ROUTES - 1);

	state_t        state_q, state_d;
	req_t          req_q;
	logic [IW-1:0] rd_idx_q;
	logic          scan_s1;
	logic [IW-1:0] idx_s1;

	logic          match_q;
	logic [IW-1:0] midx_q;
	entry_t        mentry_q;
	logic [IW-1:0] cand_idx_q;
	logic [31:0]   cand_exp_q;
	logic          cand_done_q;

	rsp_t          rsp_q, rsp_d;
	logic          rsp_vld_q;

	logic          accept;
	logic          issue;
	logic          decide_go;

	entry_t        rd_entry;
	logic          rd_vld;
	entry_t        scan_entry;
	entry_t        cmp_entry;
	cmp_t          cmp;

	logic          we;
	logic [IW-1:0] waddr;
	entry_t        wdata;
	logic          set_en;
	logic          clr_en;
	logic [IW-1:0] clr_idx;
	logic          expire_clr;
	logic          rm_ok;
	logic          upd;
	logic [31:0]   new_exp;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);

	// ---- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (req.action == ACT_REMOVE) ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (!rsp_vld_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		issue     = (state_q == ST_SCAN);
		decide_go = (state_q == ST_DECIDE) && (!rsp_vld_q || !rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			scan_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_s1 <= issue;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s1 <= rd_idx_q;
	end

	// ---- storage
	rte_store #(
		.ROUTES (ROUTES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.raddr    (rd_idx_q),
		.rd_entry (rd_entry),
		.rd_vld   (rd_vld),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.set_en   (set_en),
		.set_idx  (cand_idx_q),
		.clr_en   (clr_en),
		.clr_idx  (clr_idx)
	);

	// ---- shared comparator: scanned entry during the walk, matched entry at decision
	assign scan_entry = rd_vld ? rd_entry : '0;
	assign cmp_entry  = (state_q == ST_DECIDE) ? mentry_q : scan_entry;

	rte_cmp u_cmp (
		.ent     (cmp_entry),
		.dest    (req_q.dest_addr),
		.hop     (req_q.hop_addr),
		.cost    (req_q.route_cost),
		.now     (req_q.time_now),
		.ref_exp (cand_exp_q),
		.res     (cmp)
	);

	// ---- walk: first match, replacement candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 1'b0;
			cand_done_q <= 1'b0;
		end else if (accept) begin
			match_q <= 1'b0;
		end else if (scan_s1) begin
			if (!match_q && rd_vld && cmp.dest_eq) begin
				match_q <= 1'b1;
			end
			if (idx_s1 == '0) begin
				cand_done_q <= 1'b0;
			end else if (!cand_done_q && !rd_vld) begin
				cand_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_s1) begin
			if (!match_q && rd_vld && cmp.dest_eq) begin
				midx_q   <= idx_s1;
				mentry_q <= rd_entry;
			end
			// entry 0 seeds the candidate; first free slot from 1 up ends the search
			if (idx_s1 == '0) begin
				cand_idx_q <= '0;
				cand_exp_q <= scan_entry.expiry;
			end else if (!cand_done_q) begin
				if (!rd_vld) begin
					cand_idx_q <= idx_s1;
				end else if (cmp.older) begin
					cand_idx_q <= idx_s1;
					cand_exp_q <= scan_entry.expiry;
				end
			end
		end
	end

	// ---- decision and write-back
	always_comb begin
		new_exp    = req_q.time_now + req_q.life_span;
		upd        = cmp.due || cmp.hop_eq || cmp.cost_lt;
		rm_ok      = (32'(req_q.slot_sel) < 32'(ROUTES));
		expire_clr = scan_s1 && (req_q.action == ACT_EXPIRE) && rd_vld && cmp.due;

		wdata.dest   = req_q.dest_addr;
		wdata.hop    = req_q.hop_addr;
		wdata.cost   = req_q.route_cost;
		wdata.expiry = new_exp;

		we     = 1'b0;
		set_en = 1'b0;
		waddr  = match_q ? midx_q : cand_idx_q;
		rsp_d  = '0;

		unique case (req_q.action)
			ACT_FIND: begin
				if (match_q && !cmp.due) begin
					rsp_d.hit        = 1'b1;
					rsp_d.slot_out   = SLOT_W'(midx_q);
					rsp_d.hop_out    = mentry_q.hop;
					rsp_d.cost_out   = mentry_q.cost;
					rsp_d.expiry_out = mentry_q.expiry;
				end
			end
			ACT_UPSERT: begin
				rsp_d.hit = 1'b1;
				if (match_q) begin
					we               = decide_go && upd;
					rsp_d.slot_out   = SLOT_W'(midx_q);
					rsp_d.hop_out    = upd ? req_q.hop_addr : mentry_q.hop;
					rsp_d.cost_out   = upd ? req_q.route_cost : mentry_q.cost;
					rsp_d.expiry_out = upd ? new_exp : mentry_q.expiry;
				end else begin
					we               = decide_go;
					set_en           = decide_go;
					rsp_d.slot_out   = SLOT_W'(cand_idx_q);
					rsp_d.hop_out    = req_q.hop_addr;
					rsp_d.cost_out   = req_q.route_cost;
					rsp_d.expiry_out = new_exp;
				end
			end
			ACT_EXPIRE: ;
			ACT_REMOVE: ;
			default: ;
		endcase

		if (state_q == ST_DECIDE) begin
			clr_en  = decide_go && (req_q.action == ACT_REMOVE) && rm_ok;
			clr_idx = IW'(req_q.slot_sel);
		end else begin
			clr_en  = expire_clr;
			clr_idx = idx_s1;
		end
	end

	// ---- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (decide_go) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// ---- checks
	a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		scan_s1 |-> req_stall)
		else $error("request taken while the table walk is running");

	a_set_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(set_en && clr_en))
		else $error("valid flag set and clear in the same cycle");

	a_decide_result: assert property (@(posedge clk) disable iff (!arst_n)
		decide_go |=> rsp_valid)
		else $error("decision made but no result offered");

	a_write_in_decide: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (decide_go && (req_q.action == ACT_UPSERT)))
		else $error("route memory written outside an upsert decision");

endmodule

@@ design/rte_cmp.sv @@
// ----------------------------------------------------------------------------
// rte_cmp: route comparator
// The one compare unit of the table: checks one route word against the
// request (destination, next hop, metric, time) and against a reference
// expiry. Used for every scanned entry and again for the final decision.
// ----------------------------------------------------------------------------
module rte_cmp (
	input  rte_pkg::entry_t ent,
	input  logic [15:0]     dest,
	input  logic [15:0]     hop,
	input  logic [15:0]     cost,
	input  logic [31:0]     now,
	input  logic [31:0]     ref_exp,
	output rte_pkg::cmp_t   res
);
	import rte_pkg::*;

	always_comb begin
		res.dest_eq = (ent.dest == dest);
		res.hop_eq  = (ent.hop == hop);
		res.cost_lt = (cost < ent.cost);
		res.due     = (now >= ent.expiry);
		res.older   = (ent.expiry < ref_exp);
	end

endmodule

@@ design/rte_store.sv @@
// ----------------------------------------------------------------------------
// rte_store: route storage
// Route words in a single-port-write, single-port-read memory with
// registered read data, plus per-entry valid flags in flops.
// ----------------------------------------------------------------------------
module rte_store #(
	parameter int ROUTES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [$clog2(ROUTES)-1:0]   raddr,
	output rte_pkg::entry_t             rd_entry,
	output logic                        rd_vld,
	input  logic                        we,
	input  logic [$clog2(ROUTES)-1:0]   waddr,
	input  rte_pkg::entry_t             wdata,
	input  logic                        set_en,
	input  logic [$clog2(ROUTES)-1:0]   set_idx,
	input  logic                        clr_en,
	input  logic [$clog2(ROUTES)-1:0]   clr_idx
);
	import rte_pkg::*;

	entry_t            mem_q [ROUTES];
	entry_t            rd_entry_q;
	logic              rd_vld_q;
	logic [ROUTES-1:0] vbits_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_entry_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbits_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vbits_q[raddr];
			if (clr_en) begin
				vbits_q[clr_idx] <= 1'b0;
			end
			if (set_en) begin
				vbits_q[set_idx] <= 1'b1;
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_vld   = rd_vld_q;

endmodule

@@ verif/route_table_with_expiry_test.sv @@
// ----------------------------------------------------------------------------
// route_table_with_expiry_test: self-checking bench for the route table
// An initial block queues directed and random requests. A clocked driver
// offers them and a clocked monitor checks each response against a local
// copy of the table, across phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module route_table_with_expiry_test;
	import rte_pkg::*;

	localparam int ROUTES    = 16;
	localparam int N_RANDOM  = 800;
	localparam int N_POOL    = 24;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_t;

	typedef struct {
		req_t  req;
		idle_t idle_mode;
		bit    drain_first;
	} pending_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	route_table_with_expiry #(.ROUTES(ROUTES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local copy of the route store
	logic        tbl_valid  [ROUTES] = '{default: 1'b0};
	logic [15:0] tbl_dest   [ROUTES] = '{default: '0};
	logic [15:0] tbl_hop    [ROUTES] = '{default: '0};
	logic [15:0] tbl_cost   [ROUTES] = '{default: '0};
	logic [31:0] tbl_expiry [ROUTES] = '{default: '0};

	pending_t    pending[$];
	rsp_t        awaited_rsp[$];
	idle_t       cur_mode    = IDLE_NONE;
	int unsigned sent_count  = 0;
	int unsigned got_count   = 0;
	int unsigned bad_results = 0;

	int unsigned n_find, n_find_hit, n_upsert, n_evict, n_sweep, n_remove;

	function automatic rsp_t entry_word(input int idx);
		rsp_t res;
		res.hit        = 1'b1;
		res.slot_out   = 4'(idx);
		res.hop_out    = tbl_hop[idx];
		res.cost_out   = tbl_cost[idx];
		res.expiry_out = tbl_expiry[idx];
		return res;
	endfunction

	function automatic void wipe_entry(input int idx);
		tbl_valid[idx]  = 1'b0;
		tbl_dest[idx]   = '0;
		tbl_hop[idx]    = '0;
		tbl_cost[idx]   = '0;
		tbl_expiry[idx] = '0;
	endfunction

	// applies one request to the local table and returns the response it gives
	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		int   hit_at;
		int   pick;
		bit   free_seen;
		res    = '0;
		hit_at = -1;
		for (int i = 0; i < ROUTES; i++)
			if (hit_at < 0 && tbl_valid[i] && tbl_dest[i] == r.dest_addr)
				hit_at = i;
		case (r.action)
			ACT_FIND: begin
				n_find++;
				// the first match decides, even when it is due
				if (hit_at >= 0 && r.time_now < tbl_expiry[hit_at]) begin
					res = entry_word(hit_at);
					n_find_hit++;
				end
			end
			ACT_UPSERT: begin
				n_upsert++;
				if (hit_at >= 0) begin
					if (r.time_now >= tbl_expiry[hit_at] || tbl_hop[hit_at] == r.hop_addr
							|| r.route_cost < tbl_cost[hit_at]) begin
						tbl_hop[hit_at]    = r.hop_addr;
						tbl_cost[hit_at]   = r.route_cost;
						tbl_expiry[hit_at] = r.time_now + r.life_span;
					end
					res = entry_word(hit_at);
				end else begin
					pick      = 0;
					free_seen = 1'b0;
					// entry 0 is only ever taken as the oldest, never as free
					for (int i = 1; i < ROUTES; i++)
						if (!free_seen) begin
							if (!tbl_valid[i]) begin
								pick      = i;
								free_seen = 1'b1;
							end else if (tbl_expiry[i] < tbl_expiry[pick]) begin
								pick = i;
							end
						end
					if (!free_seen)
						n_evict++;
					tbl_valid[pick]  = 1'b1;
					tbl_dest[pick]   = r.dest_addr;
					tbl_hop[pick]    = r.hop_addr;
					tbl_cost[pick]   = r.route_cost;
					tbl_expiry[pick] = r.time_now + r.life_span;
					res = entry_word(pick);
				end
			end
			ACT_EXPIRE: begin
				n_sweep++;
				for (int i = 0; i < ROUTES; i++)
					if (tbl_valid[i] && r.time_now >= tbl_expiry[i])
						wipe_entry(i);
			end
			default: begin
				n_remove++;
				if (r.slot_sel < ROUTES)
					wipe_entry(r.slot_sel);
			end
		endcase
		return res;
	endfunction

	task automatic queue_item(input act_t act, input logic [15:0] dest, input logic [15:0] hop,
			input logic [15:0] cost, input logic [31:0] now, input logic [31:0] life,
			input logic [3:0] sel, input idle_t mode, input bit drain);
		pending_t p;
		p.req.action     = act;
		p.req.dest_addr  = dest;
		p.req.hop_addr   = hop;
		p.req.route_cost = cost;
		p.req.time_now   = now;
		p.req.life_span  = life;
		p.req.slot_sel   = sel;
		p.idle_mode      = mode;
		p.drain_first    = drain;
		pending.push_back(p);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive
		bit          took;
		bit          gap;
		int unsigned sent_so_far;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			cur_mode  <= IDLE_NONE;
		end else begin
			took        = req_valid && !req_stall;
			sent_so_far = sent_count;
			if (took) begin
				awaited_rsp.push_back(apply_request(req));
				sent_so_far++;
				sent_count <= sent_so_far;
			end
			if (took || !req_valid) begin
				gap = 1'b0;
				if (pending.size() != 0) begin
					if (pending[0].drain_first && sent_so_far != got_count)
						gap = 1'b1;
					else if (pending[0].idle_mode == IDLE_SEND)
						gap = $urandom_range(99) < 62;
					else if (pending[0].idle_mode == IDLE_BOTH)
						gap = $urandom_range(99) < 11;
				end
				if (pending.size() != 0 && !gap) begin
					req       <= pending[0].req;
					req_valid <= 1'b1;
					cur_mode  <= pending[0].idle_mode;
					pending.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got_count <= got_count + 1;
				if (awaited_rsp.size() == 0) begin
					if (bad_results < 10)
						$display("unexpected response at %0t: hit=%0d slot=%0d hop=%h",
							$realtime, rsp.hit, rsp.slot_out, rsp.hop_out);
					bad_results++;
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.hit !== want.hit || rsp.slot_out !== want.slot_out
							|| rsp.hop_out !== want.hop_out || rsp.cost_out !== want.cost_out
							|| rsp.expiry_out !== want.expiry_out) begin
						if (bad_results < 10) begin
							$display("mismatch at %0t: want hit=%0d slot=%0d hop=%h cost=%h exp=%h",
								$realtime, want.hit, want.slot_out, want.hop_out,
								want.cost_out, want.expiry_out);
							$display("  got hit=%0d slot=%0d hop=%h cost=%h exp=%h",
								rsp.hit, rsp.slot_out, rsp.hop_out, rsp.cost_out,
								rsp.expiry_out);
						end
						bad_results++;
					end
				end
			end
			case (cur_mode)
				IDLE_RECV: rsp_stall <= $urandom_range(99) < 62;
				IDLE_BOTH: rsp_stall <= $urandom_range(99) < 11;
				default:   rsp_stall <= 1'b0;
			endcase
		end
	end

	initial begin : stimulus
		logic [15:0] dest_pool [N_POOL];
		int unsigned clock_ms;
		int unsigned roll;
		act_t        act;
		logic [15:0] dest, hop, cost;
		logic [31:0] life;
		idle_t       mode;

		// directed: empty table, zero lifetime, wrap, each upsert rule, clears
		queue_item(ACT_FIND,   16'h1234, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_UPSERT, 16'h0000, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_FIND,   16'h0000, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_UPSERT, 16'h0000, 16'h0005, 16'h0009, 32'd0, 32'd0, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_UPSERT, 16'hffff, 16'hffff, 16'hffff, 32'hffff_fff0, 32'd32, 4'hf,
			IDLE_NONE, 0);
		queue_item(ACT_FIND,   16'hffff, 16'h0000, 16'h0000, 32'hffff_fff0, 32'd0, 4'd0,
			IDLE_NONE, 0);
		queue_item(ACT_UPSERT, 16'h00a0, 16'h0001, 16'd50, 32'd100, 32'd1000, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_UPSERT, 16'h00a0, 16'h0002, 16'd60, 32'd200, 32'd1000, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_UPSERT, 16'h00a0, 16'h0002, 16'd40, 32'd200, 32'd1000, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_UPSERT, 16'h00a0, 16'h0002, 16'd99, 32'd300, 32'd500, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_FIND,   16'h00a0, 16'h0000, 16'h0000, 32'd400, 32'd0, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_REMOVE, 16'h0000, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_REMOVE, 16'h0000, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'hf, IDLE_NONE, 0);
		queue_item(ACT_EXPIRE, 16'h0000, 16'h0000, 16'h0000, 32'h100, 32'd0, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_FIND,   16'hffff, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd0, IDLE_NONE, 0);
		queue_item(ACT_REMOVE, 16'h0000, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd3, IDLE_NONE, 1);
		queue_item(ACT_UPSERT, 16'h5a5a, 16'ha5a5, 16'h0001, 32'd1, 32'hffff_ffff, 4'd0,
			IDLE_NONE, 0);
		queue_item(ACT_FIND,   16'h5a5a, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd0, IDLE_NONE, 0);

		for (int j = 0; j < N_POOL; j++)
			dest_pool[j] = 16'($urandom);
		clock_ms = 1000;

		// mostly coherent traffic over a small address set so the table fills
		// and evicts; a slice of fully random requests on top
		for (int k = 0; k < N_RANDOM; k++) begin
			mode = idle_t'((k / 100) % 4);
			if ($urandom_range(99) < 8) begin
				queue_item(act_t'($urandom_range(3)), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom, $urandom, 4'($urandom), mode, k % 100 == 0);
			end else begin
				if ($urandom_range(99) < 4)
					clock_ms = $urandom;
				else
					clock_ms = clock_ms + $urandom_range(40);
				roll = $urandom_range(99);
				if (roll < 38)
					act = ACT_FIND;
				else if (roll < 80)
					act = ACT_UPSERT;
				else if (roll < 88)
					act = ACT_EXPIRE;
				else
					act = ACT_REMOVE;
				dest = dest_pool[$urandom_range(N_POOL - 1)];
				hop  = ($urandom_range(99) < 70) ? 16'($urandom_range(3)) : 16'($urandom);
				cost = ($urandom_range(99) < 70) ? 16'($urandom_range(8)) : 16'($urandom);
				roll = $urandom_range(99);
				if (roll < 5)
					life = 32'd0;
				else if (roll < 10)
					life = $urandom;
				else
					life = $urandom_range(3000, 50);
				queue_item(act, dest, hop, cost, clock_ms, life, 4'($urandom), mode,
					k % 100 == 0);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending.size() != 0 || req_valid)
			@(posedge clk);
		while (got_count != sent_count)
			@(posedge clk);
		repeat (4 * ROUTES) @(posedge clk);

		if (awaited_rsp.size() != 0) begin
			$display("%0d responses never arrived", awaited_rsp.size());
			bad_results += awaited_rsp.size();
		end
		$display("covered %0d requests: %0d find (%0d hit), %0d upsert (%0d evicting),",
			sent_count, n_find, n_find_hit, n_upsert, n_evict);
		$display("  %0d sweep, %0d remove; %0d responses checked, %0d bad",
			n_sweep, n_remove, got_count, bad_results);
		if (bad_results == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("timed out with %0d responses outstanding", sent_count - got_count);
		$display("== FAIL ==");
		$finish;
	end

endmodule
